### hdl/dspd_pkg.sv
// dual-side pid drive: shared constants, codes and control structs
// used by every module and interface of the block; no dependencies
`default_nettype none

package dspd_pkg;

  // parameter defaults
  localparam int ENC_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SUM_WIDTH_DEF = 40;

  // fixed field widths
  localparam int TGT_W      = 24;
  localparam int MAXV_W     = 7;
  localparam int DVS_W      = 8;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // quotient bits resolved per divider cycle
  localparam int RADIX_BITS = 8;

  localparam int NUM_OPS = 6;

  // register reset values
  localparam logic signed [TGT_W-1:0] RST_LEFT_TARGET  = 24'sd1000;
  localparam logic signed [TGT_W-1:0] RST_RIGHT_TARGET = 24'sd1000;
  localparam logic [MAXV_W-1:0]       RST_MAX_VEL      = 7'd50;
  localparam logic [DVS_W-1:0]        RST_P_DIV        = 8'd6;
  localparam logic [DVS_W-1:0]        RST_I_DIV        = 8'd20;
  localparam logic [DVS_W-1:0]        RST_D_DIV        = 8'd8;
  localparam logic [MAXV_W-1:0]       RST_STOP_BAND    = 7'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_TARGET  = 3'd0,
    REG_RIGHT_TARGET = 3'd1,
    REG_MAX_VEL      = 3'd2,
    REG_P_DIV        = 3'd3,
    REG_I_DIV        = 3'd4,
    REG_D_DIV        = 3'd5,
    REG_STOP_BAND    = 3'd6
  } cfg_reg_t;

  // which quotient the shared divider works on
  typedef enum logic [2:0] {
    OP_LP = 3'd0,
    OP_LI = 3'd1,
    OP_LD = 3'd2,
    OP_RP = 3'd3,
    OP_RI = 3'd4,
    OP_RD = 3'd5
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_SUM,
    ST_CLAMP,
    ST_UPDATE,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic    capture;
    logic    prep;
    logic    div_start;
    div_op_t op;
    logic    sum;
    logic    clamp;
    logic    update;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic div_done;
  } status_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic div_op_t next_op(div_op_t op);
    div_op_t nxt;
    unique case (op)
      OP_LP:   nxt = OP_LI;
      OP_LI:   nxt = OP_LD;
      OP_LD:   nxt = OP_RP;
      OP_RP:   nxt = OP_RI;
      OP_RI:   nxt = OP_RD;
      default: nxt = OP_LP;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

### hdl/dspd_in_if.sv
// request channel carrying one tick of wheel encoder readings
// depends on dspd_pkg for the default encoder width
`default_nettype none

interface dspd_in_if #(
  parameter int ENC_WIDTH = dspd_pkg::ENC_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [ENC_WIDTH-1:0] left_front_deg;
  logic signed [ENC_WIDTH-1:0] left_back_deg;
  logic signed [ENC_WIDTH-1:0] right_front_deg;
  logic signed [ENC_WIDTH-1:0] right_back_deg;
  logic                        restart;

  modport source (
    output valid, left_front_deg, left_back_deg, right_front_deg, right_back_deg, restart,
    input  ready
  );
  modport sink (
    input  valid, left_front_deg, left_back_deg, right_front_deg, right_back_deg, restart,
    output ready
  );
endinterface

`default_nettype wire

### hdl/dspd_out_if.sv
// request channel carrying the two drive commands and the done flag
// depends on dspd_pkg for the output width
`default_nettype none

interface dspd_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [dspd_pkg::OUT_W-1:0]  left_drive;
  logic signed [dspd_pkg::OUT_W-1:0]  right_drive;
  logic                               done_res;

  modport source (
    output valid, left_drive, right_drive, done_res,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, done_res,
    output ready
  );
endinterface

`default_nettype wire

### hdl/dspd_cfg_if.sv
// configuration write channel: register index and write data
// depends on dspd_pkg for index and data widths
`default_nettype none

interface dspd_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [dspd_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [dspd_pkg::CFG_DATA_W-1:0]   wr_data;

  modport source (
    output valid, reg_index, wr_data,
    input  ready
  );
  modport sink (
    input  valid, reg_index, wr_data,
    output ready
  );
endinterface

`default_nettype wire

### hdl/dspd_div.sv
// shared unsigned divider, RADIX_BITS quotient bits per cycle
// restoring long division by an 8-bit nonzero divisor; uses dspd_pkg
`default_nettype none

module dspd_div #(
  parameter int DIV_W = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [DIV_W-1:0]            dividend,
  input  wire logic [dspd_pkg::DVS_W-1:0]  divisor,
  output logic                             done,
  output logic [DIV_W-1:0]                 quotient
);

  localparam int STEPS = DIV_W / dspd_pkg::RADIX_BITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [DIV_W-1:0]           sh;
  logic [DIV_W-1:0]           sh_next;
  logic [dspd_pkg::DVS_W-1:0] rem;
  logic [dspd_pkg::DVS_W-1:0] rem_next;
  logic [dspd_pkg::DVS_W-1:0] dvs;
  logic [dspd_pkg::DVS_W:0]   trial;

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    trial    = '0;
    for (int i = 0; i < dspd_pkg::RADIX_BITS; i++) begin
      trial   = {rem_next, sh_next[DIV_W-1]};
      sh_next = sh_next << 1;
      if (trial >= {1'b0, dvs}) begin
        rem_next   = dspd_pkg::DVS_W'(trial - {1'b0, dvs});
        sh_next[0] = 1'b1;
      end else begin
        rem_next = trial[dspd_pkg::DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh  <= sh_next;
      rem <= rem_next;
    end
  end

  assign quotient = sh;

endmodule

`default_nettype wire

### hdl/dspd_ctrl.sv
// sequencer for one control tick: error prep, six divisions, sum, clamp, state update
// and output register load, or only prep and the load once the move is finished; uses dspd_pkg
`default_nettype none

module dspd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dspd_pkg::status_t status,
  output dspd_pkg::cmd_t         cmd
);

  dspd_pkg::ctrl_state_t state;
  dspd_pkg::ctrl_state_t state_next;
  dspd_pkg::div_op_t     op;
  dspd_pkg::div_op_t     op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      dspd_pkg::ST_IDLE: begin
        if (in_valid) state_next = dspd_pkg::ST_PREP;
      end
      dspd_pkg::ST_PREP: begin
        op_next = dspd_pkg::OP_LP;
        // a finished move just repeats the last drives
        state_next = status.finished ? dspd_pkg::ST_WRITE : dspd_pkg::ST_DIV_LOAD;
      end
      dspd_pkg::ST_DIV_LOAD: begin
        state_next = dspd_pkg::ST_DIV_WAIT;
      end
      dspd_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (op == dspd_pkg::OP_RD) begin
            state_next = dspd_pkg::ST_SUM;
          end else begin
            op_next    = dspd_pkg::next_op(op);
            state_next = dspd_pkg::ST_DIV_LOAD;
          end
        end
      end
      dspd_pkg::ST_SUM:    state_next = dspd_pkg::ST_CLAMP;
      dspd_pkg::ST_CLAMP:  state_next = dspd_pkg::ST_UPDATE;
      dspd_pkg::ST_UPDATE: state_next = dspd_pkg::ST_WRITE;
      dspd_pkg::ST_WRITE: begin
        if (!out_valid || out_ready) state_next = dspd_pkg::ST_IDLE;
      end
      default: state_next = dspd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == dspd_pkg::ST_IDLE);
    cmd           = '0;
    cmd.capture   = in_valid && (state == dspd_pkg::ST_IDLE);
    cmd.prep      = (state == dspd_pkg::ST_PREP);
    cmd.div_start = (state == dspd_pkg::ST_DIV_LOAD);
    cmd.op        = op;
    cmd.sum       = (state == dspd_pkg::ST_SUM);
    cmd.clamp     = (state == dspd_pkg::ST_CLAMP);
    cmd.update    = (state == dspd_pkg::ST_UPDATE);
    cmd.load_out  = (state == dspd_pkg::ST_WRITE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dspd_pkg::ST_IDLE;
      op        <= dspd_pkg::OP_LP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_start_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider finished right after its start");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == dspd_pkg::ST_DIV_WAIT))
    else $error("divider result arrived outside the wait state");

  a_last_op: assert property (@(posedge clk) disable iff (rst)
    (state == dspd_pkg::ST_DIV_WAIT && status.div_done && op == dspd_pkg::OP_RD)
      |=> (state == dspd_pkg::ST_SUM))
    else $error("sixth quotient did not lead to the sum step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while a result waits");

endmodule

`default_nettype wire

### hdl/dspd_dp.sv
// datapath: config registers, loop state, error formation, operand
// selection into the shared divider, sum, clamp and output register
// uses dspd_pkg and dspd_div
`default_nettype none

module dspd_dp #(
  parameter int ENC_WIDTH = dspd_pkg::ENC_WIDTH_DEF,
  parameter int FRAC_BITS = dspd_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH = dspd_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dspd_pkg::cmd_t                        cmd,
  output dspd_pkg::status_t                          status,
  input  wire logic                                  cfg_valid,
  input  wire logic [dspd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dspd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic signed [ENC_WIDTH-1:0]           left_front_deg,
  input  wire logic signed [ENC_WIDTH-1:0]           left_back_deg,
  input  wire logic signed [ENC_WIDTH-1:0]           right_front_deg,
  input  wire logic signed [ENC_WIDTH-1:0]           right_back_deg,
  input  wire logic                                  restart,
  output logic signed [dspd_pkg::OUT_W-1:0]          left_drive,
  output logic signed [dspd_pkg::OUT_W-1:0]          right_drive,
  output logic                                       done_res
);

  localparam int TGT_W  = dspd_pkg::TGT_W;
  localparam int RAW_W  = dspd_pkg::max_int(TGT_W, ENC_WIDTH) + 2;
  localparam int ERR_W  = RAW_W + FRAC_BITS - 1;
  localparam int DRV_W  = dspd_pkg::MAXV_W + FRAC_BITS + 1;
  localparam int CHG_W  = DRV_W + 1;
  localparam int MAXW   = dspd_pkg::max_int(dspd_pkg::max_int(ERR_W, SUM_WIDTH), CHG_W);
  localparam int DIV_W  = ((MAXW + dspd_pkg::RADIX_BITS - 1) / dspd_pkg::RADIX_BITS)
                          * dspd_pkg::RADIX_BITS;
  localparam int QW     = DIV_W + 1;
  localparam int V_W    = QW + 2;
  localparam int SS_W   = dspd_pkg::max_int(SUM_WIDTH, ERR_W) + 1;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [SS_W-1:0]      SS_MAX  = SS_W'(SUM_MAX);
  localparam logic signed [SS_W-1:0]      SS_MIN  = SS_W'(SUM_MIN);

  // configuration
  logic signed [TGT_W-1:0]           left_target;
  logic signed [TGT_W-1:0]           right_target;
  logic [dspd_pkg::MAXV_W-1:0]       max_velocity;
  logic [dspd_pkg::DVS_W-1:0]        p_divisor;
  logic [dspd_pkg::DVS_W-1:0]        i_divisor;
  logic [dspd_pkg::DVS_W-1:0]        d_divisor;
  logic [dspd_pkg::MAXV_W-1:0]       stop_band;

  // captured encoders
  logic signed [ENC_WIDTH-1:0] lf_deg;
  logic signed [ENC_WIDTH-1:0] lb_deg;
  logic signed [ENC_WIDTH-1:0] rf_deg;
  logic signed [ENC_WIDTH-1:0] rb_deg;

  // loop state
  logic signed [DRV_W-1:0]     prev_left_drive;
  logic signed [DRV_W-1:0]     prev_right_drive;
  logic signed [CHG_W-1:0]     left_drive_change;
  logic signed [CHG_W-1:0]     right_drive_change;
  logic signed [SUM_WIDTH-1:0] left_error_sum;
  logic signed [SUM_WIDTH-1:0] right_error_sum;
  logic                        finished;

  // per-tick working values
  logic signed [ERR_W-1:0]  err_l;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [QW-1:0]     quo [dspd_pkg::NUM_OPS];
  logic signed [V_W-1:0]    vraw_l;
  logic signed [V_W-1:0]    vraw_r;
  logic signed [DRV_W-1:0]  v_l;
  logic signed [DRV_W-1:0]  v_r;
  logic                     neg_r;

  // combinational
  logic signed [RAW_W-1:0]     raw_l;
  logic signed [RAW_W-1:0]     raw_r;
  logic signed [DRV_W-1:0]     lim;
  logic signed [V_W-1:0]       lim_ext;
  logic signed [DRV_W-1:0]     band;
  logic signed [DRV_W-1:0]     v_l_next;
  logic signed [DRV_W-1:0]     v_r_next;
  logic signed [SS_W-1:0]      ss_l;
  logic signed [SS_W-1:0]      ss_r;
  logic signed [SUM_WIDTH-1:0] sum_l_next;
  logic signed [SUM_WIDTH-1:0] sum_r_next;
  logic                        in_band;
  logic signed [QW-1:0]        opnd;
  logic signed [QW-1:0]        opnd_abs;
  logic [dspd_pkg::DVS_W-1:0]  dvs_raw;
  logic [dspd_pkg::DVS_W-1:0]  dvs;
  logic                        div_done;
  logic [DIV_W-1:0]            div_q;
  logic signed [QW-1:0]        q_mag;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_target  <= dspd_pkg::RST_LEFT_TARGET;
      right_target <= dspd_pkg::RST_RIGHT_TARGET;
      max_velocity <= dspd_pkg::RST_MAX_VEL;
      p_divisor    <= dspd_pkg::RST_P_DIV;
      i_divisor    <= dspd_pkg::RST_I_DIV;
      d_divisor    <= dspd_pkg::RST_D_DIV;
      stop_band    <= dspd_pkg::RST_STOP_BAND;
    end else if (cfg_valid) begin
      unique case (dspd_pkg::cfg_reg_t'(cfg_index))
        dspd_pkg::REG_LEFT_TARGET:  left_target  <= $signed(cfg_data[TGT_W-1:0]);
        dspd_pkg::REG_RIGHT_TARGET: right_target <= $signed(cfg_data[TGT_W-1:0]);
        dspd_pkg::REG_MAX_VEL:      max_velocity <= cfg_data[dspd_pkg::MAXV_W-1:0];
        dspd_pkg::REG_P_DIV:        p_divisor    <= cfg_data[dspd_pkg::DVS_W-1:0];
        dspd_pkg::REG_I_DIV:        i_divisor    <= cfg_data[dspd_pkg::DVS_W-1:0];
        dspd_pkg::REG_D_DIV:        d_divisor    <= cfg_data[dspd_pkg::DVS_W-1:0];
        dspd_pkg::REG_STOP_BAND:    stop_band    <= cfg_data[dspd_pkg::MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  // error = (2*target - front - back) * 2^(frac-1), the half degree stays exact
  assign raw_l = (RAW_W'(left_target) <<< 1) - RAW_W'(lf_deg) - RAW_W'(lb_deg);
  assign raw_r = (RAW_W'(right_target) <<< 1) - RAW_W'(rf_deg) - RAW_W'(rb_deg);

  assign lim     = {1'b0, max_velocity, {FRAC_BITS{1'b0}}};
  assign lim_ext = V_W'(lim);
  assign band    = {1'b0, stop_band, {FRAC_BITS{1'b0}}};

  // divider operand and divisor select
  always_comb begin
    unique case (cmd.op)
      dspd_pkg::OP_LP: begin opnd = QW'(err_l);              dvs_raw = p_divisor; end
      dspd_pkg::OP_LI: begin opnd = QW'(left_error_sum);     dvs_raw = i_divisor; end
      dspd_pkg::OP_LD: begin opnd = QW'(left_drive_change);  dvs_raw = d_divisor; end
      dspd_pkg::OP_RP: begin opnd = QW'(err_r);              dvs_raw = p_divisor; end
      dspd_pkg::OP_RI: begin opnd = QW'(right_error_sum);    dvs_raw = i_divisor; end
      dspd_pkg::OP_RD: begin opnd = QW'(right_drive_change); dvs_raw = d_divisor; end
      default:         begin opnd = '0;                      dvs_raw = p_divisor; end
    endcase
  end

  assign opnd_abs = opnd[QW-1] ? -opnd : opnd;
  // a zero divisor acts as one
  assign dvs      = (dvs_raw == '0) ? dspd_pkg::DVS_W'(1) : dvs_raw;
  assign q_mag    = {1'b0, div_q};

  dspd_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (opnd_abs[DIV_W-1:0]),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // clamp to plus or minus the limit
  always_comb begin
    if (vraw_l >= lim_ext) begin
      v_l_next = lim;
    end else if (vraw_l <= -lim_ext) begin
      v_l_next = -lim;
    end else begin
      v_l_next = vraw_l[DRV_W-1:0];
    end
    if (vraw_r >= lim_ext) begin
      v_r_next = lim;
    end else if (vraw_r <= -lim_ext) begin
      v_r_next = -lim;
    end else begin
      v_r_next = vraw_r[DRV_W-1:0];
    end
  end

  // saturating error accumulators
  assign ss_l = SS_W'(left_error_sum) + SS_W'(err_l);
  assign ss_r = SS_W'(right_error_sum) + SS_W'(err_r);

  always_comb begin
    if (ss_l > SS_MAX) begin
      sum_l_next = SUM_MAX;
    end else if (ss_l < SS_MIN) begin
      sum_l_next = SUM_MIN;
    end else begin
      sum_l_next = ss_l[SUM_WIDTH-1:0];
    end
    if (ss_r > SS_MAX) begin
      sum_r_next = SUM_MAX;
    end else if (ss_r < SS_MIN) begin
      sum_r_next = SUM_MIN;
    end else begin
      sum_r_next = ss_r[SUM_WIDTH-1:0];
    end
  end

  assign in_band = (v_l <= band) && (v_l >= -band) && (v_r <= band) && (v_r >= -band);

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_drive    <= {1'b0, dspd_pkg::RST_MAX_VEL, {FRAC_BITS{1'b0}}};
      prev_right_drive   <= {1'b0, dspd_pkg::RST_MAX_VEL, {FRAC_BITS{1'b0}}};
      left_drive_change  <= '0;
      right_drive_change <= '0;
      left_error_sum     <= '0;
      right_error_sum    <= '0;
      finished           <= 1'b0;
    end else if (cmd.capture && restart) begin
      prev_left_drive    <= lim;
      prev_right_drive   <= lim;
      left_drive_change  <= '0;
      right_drive_change <= '0;
      left_error_sum     <= '0;
      right_error_sum    <= '0;
      finished           <= 1'b0;
    end else if (cmd.update) begin
      left_drive_change  <= CHG_W'(prev_left_drive) - CHG_W'(v_l);
      right_drive_change <= CHG_W'(prev_right_drive) - CHG_W'(v_r);
      prev_left_drive    <= v_l;
      prev_right_drive   <= v_r;
      left_error_sum     <= sum_l_next;
      right_error_sum    <= sum_r_next;
      finished           <= in_band;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lf_deg <= left_front_deg;
      lb_deg <= left_back_deg;
      rf_deg <= right_front_deg;
      rb_deg <= right_back_deg;
    end
    if (cmd.prep) begin
      err_l <= {raw_l, {(FRAC_BITS-1){1'b0}}};
      err_r <= {raw_r, {(FRAC_BITS-1){1'b0}}};
    end
    if (cmd.div_start) begin
      neg_r <= opnd[QW-1];
    end
    // divisor is positive, so the sign follows the dividend (truncation toward zero)
    if (div_done) begin
      quo[cmd.op] <= neg_r ? -q_mag : q_mag;
    end
    if (cmd.sum) begin
      vraw_l <= V_W'(quo[dspd_pkg::OP_LP]) + V_W'(quo[dspd_pkg::OP_LI])
                - V_W'(quo[dspd_pkg::OP_LD]);
      vraw_r <= V_W'(quo[dspd_pkg::OP_RP]) + V_W'(quo[dspd_pkg::OP_RI])
                - V_W'(quo[dspd_pkg::OP_RD]);
    end
    if (cmd.clamp) begin
      v_l <= v_l_next;
      v_r <= v_r_next;
    end
    if (cmd.load_out) begin
      left_drive  <= dspd_pkg::OUT_W'(prev_left_drive);
      right_drive <= dspd_pkg::OUT_W'(prev_right_drive);
      done_res    <= finished;
    end
  end

  assign status.finished = finished;
  assign status.div_done = div_done;

endmodule

`default_nettype wire

### hdl/dual_side_pid_drive_core.sv
// dual-side pid position drive, one result per encoder tick
// each tick runs error prep, six divisions, sum, clamp and update before the output load;
//   a tick after the move is finished goes from prep straight to the output load
// throughput: one tick at a time, set by the shared divider that forms all six quotients
// the next tick is accepted while a result still waits in the output register
// reset (rst, synchronous): registers and loop state to their defaults, no result pending
`default_nettype none

module dual_side_pid_drive_core #(
  parameter int ENC_WIDTH = dspd_pkg::ENC_WIDTH_DEF,
  parameter int FRAC_BITS = dspd_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH = dspd_pkg::SUM_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dspd_in_if.sink     tick,
  dspd_out_if.source  drive,
  dspd_cfg_if.sink    cfg
);

  dspd_pkg::cmd_t    cmd;
  dspd_pkg::status_t status;
  logic              in_ready;
  logic              out_valid;

  assign tick.ready  = in_ready;
  assign drive.valid = out_valid;
  assign cfg.ready   = 1'b1;

  dspd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (drive.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dspd_dp #(
    .ENC_WIDTH (ENC_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.reg_index),
    .cfg_data        (cfg.wr_data),
    .left_front_deg  (ENC_WIDTH'(tick.left_front_deg)),
    .left_back_deg   (ENC_WIDTH'(tick.left_back_deg)),
    .right_front_deg (ENC_WIDTH'(tick.right_front_deg)),
    .right_back_deg  (ENC_WIDTH'(tick.right_back_deg)),
    .restart         (tick.restart),
    .left_drive      (drive.left_drive),
    .right_drive     (drive.right_drive),
    .done_res        (drive.done_res)
  );

endmodule

`default_nettype wire
